>>> rtl/hsb_pkg.sv
// hsb_pkg: shared types and constants for the hardware semaphore bank
// command codes, configuration register indexes and the request struct
// no dependencies
package hsb_pkg;

	typedef enum logic [2:0] {
		CMD_LOCK_WR   = 3'd0,
		CMD_LOCK_RD   = 3'd1,
		CMD_FAST_LOCK = 3'd2,
		CMD_EN_WR     = 3'd3,
		CMD_EN_RD     = 3'd4,
		CMD_STAT_RD   = 3'd5,
		CMD_STAT_CLR  = 3'd6,
		CMD_NONE      = 3'd7
	} cmd_t;

	localparam int unsigned CODE_W = 4;
	localparam int unsigned PID_W  = 8;
	localparam int unsigned SEM_W  = 5;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CODE = 1'd1;

	localparam logic [CODE_W-1:0] FIRST_CODE_RST  = 4'd3;
	localparam logic [CODE_W-1:0] SECOND_CODE_RST = 4'd1;

	// one bus access as seen by the lock table and the interrupt block
	typedef struct packed {
		logic              act;
		cmd_t              cmd;
		logic              core;
		logic [SEM_W-1:0]  sem;
		logic [PID_W-1:0]  pid;
		logic              lock;
		logic [CODE_W-1:0] code;
	} req_t;

endpackage

>>> rtl/hsb_lock_table.sv
// hsb_lock_table: lock bits and owner fields of the semaphores
// handles lock writes, lock reads and fast-lock reads
// depends on hsb_pkg
module hsb_lock_table #(
	parameter int NUM_SEMAPHORES = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hsb_pkg::req_t                     req,
	output logic [hsb_pkg::WORD_W-1:0]        rd_word,
	output logic [NUM_SEMAPHORES-1:0]         freed_vec
);

	localparam int IW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
	localparam logic [hsb_pkg::SEM_W:0] SEM_LIMIT = (hsb_pkg::SEM_W + 1)'(NUM_SEMAPHORES);

	logic [NUM_SEMAPHORES-1:0]        locked_q;
	logic [hsb_pkg::CODE_W-1:0]       owner_core_q [NUM_SEMAPHORES];
	logic [hsb_pkg::PID_W-1:0]        owner_pid_q  [NUM_SEMAPHORES];

	logic                             sem_ok;
	logic [IW-1:0]                    idx;
	logic                             cur_lock;
	logic [hsb_pkg::CODE_W-1:0]       cur_core;
	logic [hsb_pkg::PID_W-1:0]        cur_pid;
	logic                             take;
	logic                             rel;
	logic                             eff_lock;
	logic [hsb_pkg::CODE_W-1:0]       eff_core;
	logic [hsb_pkg::PID_W-1:0]        eff_pid;
	logic                             is_fast;

	always_comb begin
		sem_ok   = {1'b0, req.sem} < SEM_LIMIT;
		idx      = req.sem[IW-1:0];
		cur_lock = sem_ok && locked_q[idx];
		cur_core = owner_core_q[idx];
		cur_pid  = owner_pid_q[idx];
		is_fast  = (req.cmd == hsb_pkg::CMD_FAST_LOCK);
		take = req.act && sem_ok && !cur_lock &&
			(((req.cmd == hsb_pkg::CMD_LOCK_WR) && req.lock) || is_fast);
		rel  = req.act && (req.cmd == hsb_pkg::CMD_LOCK_WR) && !req.lock && cur_lock &&
			(cur_core == req.code) && (cur_pid == req.pid);
		// owner fields of a free entry are stale, so mask them with the lock bit
		eff_lock = cur_lock || take;
		eff_core = (take ? req.code : cur_core) & {hsb_pkg::CODE_W{eff_lock}};
		eff_pid  = (take ? '0 : cur_pid) & {hsb_pkg::PID_W{eff_lock}};
		if (req.act && sem_ok && ((req.cmd == hsb_pkg::CMD_LOCK_RD) || is_fast)) begin
			rd_word = {eff_lock, 19'd0, eff_core, eff_pid};
		end else begin
			rd_word = '0;
		end
		freed_vec = rel ? (NUM_SEMAPHORES'(1) << idx) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q <= '0;
		end else if (take) begin
			locked_q[idx] <= 1'b1;
		end else if (rel) begin
			locked_q[idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			owner_core_q[idx] <= req.code;
			owner_pid_q[idx]  <= is_fast ? '0 : req.pid;
		end
	end

endmodule

>>> rtl/hsb_irq_ctrl.sv
// hsb_irq_ctrl: per-core interrupt enable and freed status words
// gives mask reads and the interrupt level after each access
// depends on hsb_pkg
module hsb_irq_ctrl #(
	parameter int NUM_SEMAPHORES = 32,
	parameter int NUM_CORES      = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hsb_pkg::req_t                req,
	input  logic [hsb_pkg::WORD_W-1:0]   wdata,
	input  logic [NUM_SEMAPHORES-1:0]    freed_vec,
	output logic [hsb_pkg::WORD_W-1:0]   rd_word,
	output logic [1:0]                   irq_next
);

	logic [NUM_SEMAPHORES-1:0] enable_q [NUM_CORES];
	logic [NUM_SEMAPHORES-1:0] status_q [NUM_CORES];
	logic [NUM_SEMAPHORES-1:0] enable_n [NUM_CORES];
	logic [NUM_SEMAPHORES-1:0] status_n [NUM_CORES];
	logic [NUM_SEMAPHORES-1:0] wmask;

	always_comb begin
		wmask = wdata[NUM_SEMAPHORES-1:0];
		irq_next = '0;
		for (int c = 0; c < NUM_CORES; c++) begin
			enable_n[c] = enable_q[c];
			status_n[c] = status_q[c];
			if (req.act && (req.core == 1'(c))) begin
				if (req.cmd == hsb_pkg::CMD_EN_WR) begin
					enable_n[c] = wmask;
				end
				if (req.cmd == hsb_pkg::CMD_STAT_CLR) begin
					status_n[c] = status_q[c] & ~wmask;
				end
			end
			// a release notifies every core
			status_n[c] = status_n[c] | freed_vec;
			irq_next[c] = |(status_n[c] & enable_n[c]);
		end
		rd_word = '0;
		if (req.act) begin
			if (req.cmd == hsb_pkg::CMD_EN_RD) begin
				rd_word = hsb_pkg::WORD_W'(enable_q[req.core]);
			end else if (req.cmd == hsb_pkg::CMD_STAT_RD) begin
				rd_word = hsb_pkg::WORD_W'(status_q[req.core] & enable_q[req.core]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CORES; c++) begin
				enable_q[c] <= '0;
				status_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < NUM_CORES; c++) begin
				enable_q[c] <= enable_n[c];
				status_q[c] <= status_n[c];
			end
		end
	end

endmodule

>>> rtl/hardware_semaphore_bank.sv
// hardware_semaphore_bank: 32-channel semaphore peripheral for two cores
// an accepted word is held in the input register, then its result word in the result register
// one access per cycle while no result word is held back, set by the single input and output registers
// reset: all semaphores free, enables and freed status clear, core codes 3 and 1
// depends on hsb_pkg, hsb_lock_table and hsb_irq_ctrl
module hardware_semaphore_bank #(
	parameter int NUM_SEMAPHORES = 32,
	parameter int NUM_CORES      = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// access channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       cmd,
	input  logic                             requester,
	input  logic [hsb_pkg::SEM_W-1:0]        sem_index,
	input  logic [hsb_pkg::PID_W-1:0]        proc_id,
	input  logic                             lock_bit,
	input  logic [hsb_pkg::WORD_W-1:0]       write_word,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [hsb_pkg::WORD_W-1:0]       read_data,
	output logic                             first_cpu_irq,
	output logic                             second_cpu_irq,
	// configuration channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hsb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hsb_pkg::CODE_W-1:0]       cfg_data
);

	localparam logic [1:0] CORE_LIMIT = 2'(NUM_CORES);
	localparam logic [hsb_pkg::SEM_W:0] SEM_LIMIT = (hsb_pkg::SEM_W + 1)'(NUM_SEMAPHORES);

	// input register stage
	logic                            valid_s1;
	hsb_pkg::cmd_t                   cmd_s1;
	logic                            requester_s1;
	logic [hsb_pkg::SEM_W-1:0]       sem_s1;
	logic [hsb_pkg::PID_W-1:0]       pid_s1;
	logic                            lock_s1;
	logic [hsb_pkg::WORD_W-1:0]      word_s1;

	// result register
	logic                            out_valid_q;
	logic [hsb_pkg::WORD_W-1:0]      read_data_q;
	logic [1:0]                      irq_q;

	// core codes
	logic [hsb_pkg::CODE_W-1:0]      first_code_q;
	logic [hsb_pkg::CODE_W-1:0]      second_code_q;

	logic                            out_free;
	logic                            fire;
	logic                            req_ok;
	hsb_pkg::req_t                   req;
	logic [hsb_pkg::WORD_W-1:0]      lock_rd;
	logic [hsb_pkg::WORD_W-1:0]      irq_rd;
	logic [NUM_SEMAPHORES-1:0]       freed_vec;
	logic [1:0]                      irq_next;

	// the result register frees up when empty or when its word is taken
	assign out_free  = !out_valid_q || out_ready;
	assign fire      = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	// an access from a core that is not fitted does nothing and reads 0
	assign req_ok = {1'b0, requester_s1} < CORE_LIMIT;

	always_comb begin
		req.act  = fire && req_ok;
		req.cmd  = cmd_s1;
		req.core = requester_s1;
		req.sem  = sem_s1;
		req.pid  = pid_s1;
		req.lock = lock_s1;
		req.code = requester_s1 ? second_code_q : first_code_q;
	end

	hsb_lock_table #(
		.NUM_SEMAPHORES (NUM_SEMAPHORES)
	) u_lock_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rd_word   (lock_rd),
		.freed_vec (freed_vec)
	);

	hsb_irq_ctrl #(
		.NUM_SEMAPHORES (NUM_SEMAPHORES),
		.NUM_CORES      (NUM_CORES)
	) u_irq_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.wdata     (word_s1),
		.freed_vec (freed_vec),
		.rd_word   (irq_rd),
		.irq_next  (irq_next)
	);

	// input stage: valid bit under reset, payload without
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1       <= hsb_pkg::cmd_t'(cmd);
			requester_s1 <= requester;
			sem_s1       <= sem_index;
			pid_s1       <= proc_id;
			lock_s1      <= lock_bit;
			word_s1      <= write_word;
		end
	end

	// result stage: irq levels are the ones left after the access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			irq_q       <= '0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
			if (fire) begin
				irq_q <= irq_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_data_q <= lock_rd | irq_rd;
		end
	end

	// core code registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_code_q  <= hsb_pkg::FIRST_CODE_RST;
			second_code_q <= hsb_pkg::SECOND_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hsb_pkg::CFG_FIRST_CODE:  first_code_q  <= cfg_data;
				hsb_pkg::CFG_SECOND_CODE: second_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;
	assign first_cpu_irq  = irq_q[0];
	assign second_cpu_irq = irq_q[1];

	// write commands never return data
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (cmd_s1 == hsb_pkg::CMD_LOCK_WR || cmd_s1 == hsb_pkg::CMD_EN_WR ||
			cmd_s1 == hsb_pkg::CMD_STAT_CLR)) |=> (read_data == '0))
		else $error("write command returned nonzero read data");

	// a fast lock on a valid semaphore always reads back as locked
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req_ok && (cmd_s1 == hsb_pkg::CMD_FAST_LOCK) &&
			({1'b0, sem_s1} < SEM_LIMIT)) |=> read_data[31])
		else $error("fast lock did not return a locked word");

	// the input side only stalls on a full pipe with a blocked result
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without back pressure");

	// no interrupt from a core that is not fitted
	assert property (@(posedge clk) disable iff (!arst_n)
		(NUM_CORES < 2) |-> !second_cpu_irq)
		else $error("interrupt raised for an absent core");

endmodule

>>> sim/tb_hardware_semaphore_bank.sv
// tb_hardware_semaphore_bank: self-checking bench for the semaphore bank
// drives bus accesses and core code writes, predicts every result word in place
// depends on hsb_pkg and hardware_semaphore_bank
module tb_hardware_semaphore_bank;

	// no accepted word on any channel for this many cycles means the block has hung
	localparam int STALL_LIMIT = 4000;
	// receiver hold-off long enough to fill the two pipeline registers and stall the input
	localparam int RX_HOLD_CYCLES = 300;

	typedef struct {
		hsb_pkg::cmd_t op;
		logic          req;
		logic [4:0]    sem;
		logic [7:0]    pid;
		logic          lk;
		logic [31:0]   word;
	} access_t;

	typedef struct {
		logic [31:0] rdata;
		logic        irq0;
		logic        irq1;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  cmd = hsb_pkg::CMD_NONE;
	logic        requester = 1'b0;
	logic [4:0]  sem_index = '0;
	logic [7:0]  proc_id = '0;
	logic        lock_bit = 1'b0;
	logic [31:0] write_word = '0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] read_data;
	logic        first_cpu_irq;
	logic        second_cpu_irq;

	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [hsb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [hsb_pkg::CODE_W-1:0]    cfg_data = '0;

	// predicted semaphore state, mirrors the bank
	logic        sem_locked [32] = '{default: 1'b0};
	logic [3:0]  sem_core [32] = '{default: 4'd0};
	logic [7:0]  sem_proc [32] = '{default: 8'd0};
	logic [31:0] irq_en [2] = '{default: 32'd0};
	logic [31:0] freed [2] = '{default: 32'd0};
	logic [3:0]  core_code [2] = '{hsb_pkg::FIRST_CODE_RST, hsb_pkg::SECOND_CODE_RST};

	access_t access_backlog [$];
	result_t due_results [$];
	access_t drv_item;

	int tx_idle_pct = 37;
	int rx_idle_pct = 66;
	bit rx_hold_req = 1'b0;
	int rx_hold_left = 0;

	int err_cnt = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_takes = 0;
	int n_releases = 0;
	int idle_cycles = 0;

	hardware_semaphore_bank uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.requester(requester),
		.sem_index(sem_index),
		.proc_id(proc_id),
		.lock_bit(lock_bit),
		.write_word(write_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.first_cpu_irq(first_cpu_irq),
		.second_cpu_irq(second_cpu_irq),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// lock register layout: lock in bit 31, core code in 11:8, process in 7:0
	function automatic logic [31:0] lock_reg(input logic [4:0] s);
		return {sem_locked[s], 19'd0, sem_core[s], sem_proc[s]};
	endfunction

	// applies one access to the predicted state and returns the word the bank should give
	function automatic result_t apply_access(input access_t a);
		result_t r;
		logic [3:0] code;
		r.rdata = '0;
		code = core_code[a.req];
		case (a.op)
			hsb_pkg::CMD_LOCK_WR: begin
				if (a.lk) begin
					// a locked semaphore ignores any take, even from its owner
					if (!sem_locked[a.sem]) begin
						sem_locked[a.sem] = 1'b1;
						sem_core[a.sem] = code;
						sem_proc[a.sem] = a.pid;
						n_takes++;
					end
				end else if (sem_locked[a.sem] && sem_core[a.sem] == code
						&& sem_proc[a.sem] == a.pid) begin
					// only the exact owner frees, and both cores hear of it
					sem_locked[a.sem] = 1'b0;
					sem_core[a.sem] = '0;
					sem_proc[a.sem] = '0;
					freed[0][a.sem] = 1'b1;
					freed[1][a.sem] = 1'b1;
					n_releases++;
				end
			end
			hsb_pkg::CMD_LOCK_RD: r.rdata = lock_reg(a.sem);
			hsb_pkg::CMD_FAST_LOCK: begin
				// fast lock stores process 0; on a locked semaphore it just reports the owner
				if (!sem_locked[a.sem]) begin
					sem_locked[a.sem] = 1'b1;
					sem_core[a.sem] = code;
					sem_proc[a.sem] = '0;
					n_takes++;
				end
				r.rdata = lock_reg(a.sem);
			end
			hsb_pkg::CMD_EN_WR: irq_en[a.req] = a.word;
			hsb_pkg::CMD_EN_RD: r.rdata = irq_en[a.req];
			hsb_pkg::CMD_STAT_RD: r.rdata = freed[a.req] & irq_en[a.req];
			hsb_pkg::CMD_STAT_CLR: freed[a.req] = freed[a.req] & ~a.word;
			default: ;
		endcase
		r.irq0 = |(freed[0] & irq_en[0]);
		r.irq1 = |(freed[1] & irq_en[1]);
		return r;
	endfunction

	// driver: offers the next queued access once the previous word has gone
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				due_results.push_back(apply_access(drv_item));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (access_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					drv_item = access_backlog.pop_front();
					in_valid <= 1'b1;
					cmd <= drv_item.op;
					requester <= drv_item.req;
					sem_index <= drv_item.sem;
					proc_id <= drv_item.pid;
					lock_bit <= drv_item.lk;
					write_word <= drv_item.word;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result word against the oldest prediction, then picks ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					err_cnt++;
					$display("%0t: result word with nothing predicted, read_data %h", $time,
						read_data);
				end else begin
					result_t want;
					want = due_results.pop_front();
					n_checked++;
					if (read_data !== want.rdata) begin
						err_cnt++;
						$display("%0t: read_data expected %h, got %h", $time, want.rdata,
							read_data);
					end
					if (first_cpu_irq !== want.irq0) begin
						err_cnt++;
						$display("%0t: first_cpu_irq expected %b, got %b", $time, want.irq0,
							first_cpu_irq);
					end
					if (second_cpu_irq !== want.irq1) begin
						err_cnt++;
						$display("%0t: second_cpu_irq expected %b, got %b", $time, want.irq1,
							second_cpu_irq);
					end
				end
			end
			// a requested hold-off is counted out here, whatever the idling mode
			if (rx_hold_req) begin
				rx_hold_left = RX_HOLD_CYCLES;
				rx_hold_req = 1'b0;
			end
			if (rx_hold_left != 0) begin
				rx_hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// watchdog on forward progress of any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic push_access(input hsb_pkg::cmd_t op, input logic req, input logic [4:0] sem,
			input logic [7:0] pid, input logic lk, input logic [31:0] word);
		access_t a;
		a.op = op;
		a.req = req;
		a.sem = sem;
		a.pid = pid;
		a.lk = lk;
		a.word = word;
		access_backlog.push_back(a);
	endtask

	// waits until every queued access has been sent and every result word has come back
	// sampled on the falling edge so that the driver's and monitor's updates have settled
	task automatic wait_drained();
		while (access_backlog.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
	endtask

	// core code writes happen only with the bank idle
	task automatic write_core_code(input logic [hsb_pkg::CFG_IDX_W-1:0] idx,
			input logic [3:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		core_code[idx] = val;
	endtask

	// a few hot semaphores and processes so that takes and releases meet often
	function automatic logic [4:0] random_sem();
		if ($urandom_range(0, 99) < 70)
			return 5'($urandom_range(0, 3));
		return 5'($urandom_range(0, 31));
	endfunction

	function automatic logic [7:0] random_pid();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'hff;
			2, 3: return 8'($urandom_range(1, 3));
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic logic [31:0] random_mask();
		case ($urandom_range(0, 4))
			0: return '1;
			1: return 32'd1 << $urandom_range(0, 31);
			2: return 32'($urandom_range(0, 15));
			default: return $urandom();
		endcase
	endfunction

	function automatic hsb_pkg::cmd_t random_op();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 34) return hsb_pkg::CMD_LOCK_WR;
		if (r < 48) return hsb_pkg::CMD_LOCK_RD;
		if (r < 58) return hsb_pkg::CMD_FAST_LOCK;
		if (r < 67) return hsb_pkg::CMD_EN_WR;
		if (r < 74) return hsb_pkg::CMD_EN_RD;
		if (r < 84) return hsb_pkg::CMD_STAT_RD;
		if (r < 97) return hsb_pkg::CMD_STAT_CLR;
		return hsb_pkg::CMD_NONE;
	endfunction

	// mostly take / read back / release / status sequences with random content, rest noise
	task automatic queue_random(input int n);
		int pushed;
		logic [4:0] s;
		logic [7:0] p;
		logic r;
		pushed = 0;
		while (pushed < n) begin
			if ($urandom_range(0, 99) < 60) begin
				s = random_sem();
				p = random_pid();
				r = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 3) == 0)
					push_access(hsb_pkg::CMD_FAST_LOCK, r, s, 8'($urandom()), 1'($urandom()),
						$urandom());
				else
					push_access(hsb_pkg::CMD_LOCK_WR, r, s, p, 1'b1, $urandom());
				push_access(hsb_pkg::CMD_LOCK_RD, 1'($urandom()), s, 8'($urandom()),
					1'($urandom()), $urandom());
				// occasionally release from the wrong side or with a stray process
				if ($urandom_range(0, 4) == 0)
					push_access(hsb_pkg::CMD_LOCK_WR, 1'($urandom()), s, random_pid(), 1'b0,
						$urandom());
				else
					push_access(hsb_pkg::CMD_LOCK_WR, r, s, p, 1'b0, $urandom());
				push_access(hsb_pkg::CMD_STAT_RD, 1'($urandom()), random_sem(), 8'($urandom()),
					1'($urandom()), $urandom());
				pushed += 4;
			end else begin
				push_access(random_op(), 1'($urandom()), random_sem(), random_pid(),
					1'($urandom()), random_mask());
				pushed++;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part with the reset core codes: both cores listen to every semaphore
		push_access(hsb_pkg::CMD_EN_WR, 1'b0, 5'd0, 8'd0, 1'b0, '1);
		push_access(hsb_pkg::CMD_EN_WR, 1'b1, 5'd0, 8'd0, 1'b0, '1);
		push_access(hsb_pkg::CMD_LOCK_WR, 1'b0, 5'd0, 8'hff, 1'b1, '0);
		// take of a locked semaphore, from the other core and then from the owner
		push_access(hsb_pkg::CMD_LOCK_WR, 1'b1, 5'd0, 8'h01, 1'b1, '0);
		push_access(hsb_pkg::CMD_LOCK_WR, 1'b0, 5'd0, 8'hff, 1'b1, '0);
		push_access(hsb_pkg::CMD_LOCK_RD, 1'b1, 5'd0, 8'd0, 1'b0, '1);
		// release with the wrong core, then with the wrong process
		push_access(hsb_pkg::CMD_LOCK_WR, 1'b1, 5'd0, 8'hff, 1'b0, '0);
		push_access(hsb_pkg::CMD_LOCK_WR, 1'b0, 5'd0, 8'h00, 1'b0, '0);
		push_access(hsb_pkg::CMD_LOCK_WR, 1'b0, 5'd0, 8'hff, 1'b0, '0);
		push_access(hsb_pkg::CMD_STAT_RD, 1'b0, 5'd0, 8'd0, 1'b0, '0);
		push_access(hsb_pkg::CMD_STAT_CLR, 1'b0, 5'd0, 8'd0, 1'b0, 32'd1);
		push_access(hsb_pkg::CMD_STAT_RD, 1'b1, 5'd31, 8'hff, 1'b1, '1);
		// release of a free semaphore sets no freed bit
		push_access(hsb_pkg::CMD_LOCK_WR, 1'b1, 5'd31, 8'd0, 1'b0, '0);
		push_access(hsb_pkg::CMD_FAST_LOCK, 1'b1, 5'd31, 8'hff, 1'b1, '1);
		// fast lock on a locked semaphore only reports the owner
		push_access(hsb_pkg::CMD_FAST_LOCK, 1'b0, 5'd31, 8'd0, 1'b0, '0);
		push_access(hsb_pkg::CMD_LOCK_WR, 1'b1, 5'd31, 8'd0, 1'b0, '0);
		push_access(hsb_pkg::CMD_LOCK_RD, 1'b0, 5'd31, 8'd0, 1'b0, '0);
		push_access(hsb_pkg::CMD_STAT_RD, 1'b0, 5'd0, 8'd0, 1'b0, '0);
		push_access(hsb_pkg::CMD_EN_RD, 1'b1, 5'd0, 8'd0, 1'b0, '0);
		push_access(hsb_pkg::CMD_STAT_CLR, 1'b1, 5'd0, 8'd0, 1'b0, '1);
		push_access(hsb_pkg::CMD_EN_WR, 1'b0, 5'd0, 8'd0, 1'b0, 32'h8000_0000);
		push_access(hsb_pkg::CMD_EN_RD, 1'b0, 5'd0, 8'd0, 1'b0, '0);
		push_access(hsb_pkg::CMD_NONE, 1'b1, 5'd31, 8'hff, 1'b1, '1);
		push_access(hsb_pkg::CMD_STAT_CLR, 1'b0, 5'd0, 8'd0, 1'b0, '1);
		push_access(hsb_pkg::CMD_STAT_RD, 1'b0, 5'd0, 8'd0, 1'b0, '0);
		wait_drained();

		// extreme core codes, sender sparse and receiver slow
		write_core_code(hsb_pkg::CFG_FIRST_CODE, 4'd0);
		write_core_code(hsb_pkg::CFG_SECOND_CODE, 4'd15);
		queue_random(200);
		while (access_backlog.size() > 100)
			@(posedge clk);
		// long receiver hold-off while the sender keeps offering words
		rx_hold_req = 1'b1;
		queue_random(220);
		wait_drained();

		// swapped extremes, idling the other way round
		tx_idle_pct = 66;
		rx_idle_pct = 37;
		write_core_code(hsb_pkg::CFG_FIRST_CODE, 4'd15);
		write_core_code(hsb_pkg::CFG_SECOND_CODE, 4'd0);
		queue_random(210);
		// sender stops until every outstanding result word is back
		wait_drained();
		queue_random(210);
		wait_drained();

		// equal codes, so either core can release the other's semaphore; full rate
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_core_code(hsb_pkg::CFG_FIRST_CODE, 4'd7);
		write_core_code(hsb_pkg::CFG_SECOND_CODE, 4'd7);
		queue_random(400);
		wait_drained();

		// allow any stray result word to show up
		repeat (6) @(posedge clk);

		$display("summary: %0d accesses sent, %0d result words checked, %0d errors",
			n_accepted, n_checked, err_cnt);
		$display("summary: %0d takes and %0d releases across four core code settings",
			n_takes, n_releases);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
